// ===== hdl/i128dm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i128dm_pkg
// Shared types and constants of the pipelined 128-bit divider.
// ----------------------------------------------------------------------------
package i128dm_pkg;

    // Width of one operand and of one of its halves.
    localparam int DATA_WIDTH = 128;
    localparam int HALF_WIDTH = 64;

    // One restoring step per quotient bit.
    localparam int STEP_COUNT = DATA_WIDTH;

    // One input item.
    typedef struct packed {
        logic                  signed_mode;
        logic [HALF_WIDTH-1:0] dividend_high;
        logic [HALF_WIDTH-1:0] dividend_low;
        logic [HALF_WIDTH-1:0] divisor_high;
        logic [HALF_WIDTH-1:0] divisor_low;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [HALF_WIDTH-1:0] quotient_high;
        logic [HALF_WIDTH-1:0] quotient_low;
        logic [HALF_WIDTH-1:0] remainder_high;
        logic [HALF_WIDTH-1:0] remainder_low;
        logic                  divide_by_zero;
    } t_out_item;

    // State that travels down the divider stages. The field quo_div holds the
    // dividend bits still to be consumed at its top and the quotient bits
    // already found at its bottom.
    typedef struct packed {
        logic                  neg_quotient;
        logic                  neg_remainder;
        logic                  divide_by_zero;
        logic [DATA_WIDTH-1:0] divisor;
        logic [DATA_WIDTH-1:0] remainder;
        logic [DATA_WIDTH-1:0] quo_div;
    } t_div_state;

endpackage
`default_nettype wire

// ===== hdl/i128dm_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i128dm_step
// One registered restoring-division step: shift in one dividend bit, try the
// subtraction, and shift the quotient bit in.
// ----------------------------------------------------------------------------
module i128dm_step (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire i128dm_pkg::t_div_state i_state,
    output logic                    o_valid,
    output i128dm_pkg::t_div_state  o_state
);

    localparam int W = i128dm_pkg::DATA_WIDTH;

    logic                   r_valid;
    i128dm_pkg::t_div_state r_state;
    i128dm_pkg::t_div_state n_state;
    logic [W:0]             shifted;
    logic [W+1:0]           diff;
    logic                   fits;

    // Partial remainder with the next dividend bit, and the trial subtraction.
    always_comb begin
        shifted = {i_state.remainder, i_state.quo_div[W-1]};
        diff    = {1'b0, shifted} - {2'b00, i_state.divisor};
        fits    = ~diff[W+1];
        n_state = i_state;
        n_state.remainder = fits ? diff[W-1:0] : shifted[W-1:0];
        n_state.quo_div   = {i_state.quo_div[W-2:0], fits};
    end

    // Valid bit of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule
`default_nettype wire

// ===== hdl/int128_divide_modulo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// int128_divide_modulo
// Pipelined 128-bit signed or unsigned divider giving quotient and remainder.
// ----------------------------------------------------------------------------
// The divider accepts one item in every cycle unless the input is stalled, and
// passes each through its stages: one stage takes the operand magnitudes, 128
// restoring-division stages each produce one quotient bit with a 129-bit
// subtraction, and one stage restores the signs into the output register.
// Results leave in the order the items came in. When the output is stalled
// while a result waits, the whole pipeline holds and the input is stalled.
// Signed mode truncates toward zero, the remainder takes the dividend's sign,
// and the most negative value divided by minus one wraps. A zero divisor sets
// divide_by_zero and returns a zero quotient and remainder.
module int128_divide_modulo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire i128dm_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output i128dm_pkg::t_out_item  o_out_data
);

    localparam int W = i128dm_pkg::DATA_WIDTH;
    localparam int H = i128dm_pkg::HALF_WIDTH;
    localparam int N = i128dm_pkg::STEP_COUNT;

    logic                   advance;
    logic [W-1:0]           dividend;
    logic [W-1:0]           divisor;
    logic                   neg_n;
    logic                   neg_d;
    i128dm_pkg::t_div_state n_front;
    logic                   r_front_valid;
    i128dm_pkg::t_div_state r_front;

    logic                   stage_valid [N+1];
    i128dm_pkg::t_div_state stage_state [N+1];

    i128dm_pkg::t_div_state last;
    logic [W-1:0]           quotient;
    logic [W-1:0]           remainder;
    i128dm_pkg::t_out_item  n_out;
    logic                   r_out_valid;
    i128dm_pkg::t_out_item  r_out;

    // The pipeline moves unless a finished result waits on a stalled output.
    assign advance    = ~(r_out_valid & i_out_stall);
    assign o_in_stall = ~advance;

    // Operand magnitudes and the sign corrections to apply at the end.
    always_comb begin
        dividend = {i_in_data.dividend_high, i_in_data.dividend_low};
        divisor  = {i_in_data.divisor_high, i_in_data.divisor_low};
        neg_n    = i_in_data.signed_mode & dividend[W-1];
        neg_d    = i_in_data.signed_mode & divisor[W-1];
        n_front.neg_quotient   = neg_n ^ neg_d;
        n_front.neg_remainder  = neg_n;
        n_front.divide_by_zero = (divisor == '0);
        n_front.divisor        = neg_d ? (~divisor + W'(1)) : divisor;
        n_front.remainder      = '0;
        n_front.quo_div        = neg_n ? (~dividend + W'(1)) : dividend;
    end

    // Front stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (advance) begin
            r_front_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_front <= n_front;
        end
    end

    assign stage_valid[0] = r_front_valid;
    assign stage_state[0] = r_front;

    // Chain of restoring-division stages, one quotient bit each.
    for (genvar g = 0; g < N; g++) begin : g_step
        i128dm_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (stage_valid[g]),
            .i_state (stage_state[g]),
            .o_valid (stage_valid[g+1]),
            .o_state (stage_state[g+1])
        );
    end

    // Sign restore and zero-divisor override.
    always_comb begin
        last      = stage_state[N];
        quotient  = last.neg_quotient ? (~last.quo_div + W'(1)) : last.quo_div;
        remainder = last.neg_remainder ? (~last.remainder + W'(1)) : last.remainder;
        if (last.divide_by_zero) begin
            quotient  = '0;
            remainder = '0;
        end
        n_out.quotient_high  = quotient[W-1:H];
        n_out.quotient_low   = quotient[H-1:0];
        n_out.remainder_high = remainder[W-1:H];
        n_out.remainder_low  = remainder[H-1:0];
        n_out.divide_by_zero = last.divide_by_zero;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stage_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
